FILE: src/kvt_pkg.sv
// Shared types and constants of the key-value table.
package kvt_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ENTRY_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic        [CMD_W-1:0]   cmd;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic        [STAT_W-1:0]  status;
    logic signed [VALUE_W-1:0] read_value;
    logic        [ENTRY_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic              load_item;
    logic              clr_idx;
    logic              inc_idx;
    logic              mem_we;
    logic              wr_shift;
    logic              inc_count;
    logic              dec_count;
    logic              set_res;
    logic [STAT_W-1:0] res_status;
    logic              res_take_rd;
    logic              load_out;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             idx_end;
    logic             hit;
    logic             full;
    logic             out_free;
  } stat_t;

endpackage

FILE: src/kvt_ctrl.sv
// Sequencer of the key-value table: search, append, update and shift-down steps.
module kvt_ctrl
  import kvt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  stat_t  stat_i,
  output ctrl_t  ctrl_o
);

  state_e state_q, state_d;

  logic known_cmd;
  assign known_cmd = stat_i.cmd inside {CMD_PUT, CMD_GET, CMD_REMOVE};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (!known_cmd || stat_i.idx_end) state_d = ST_RESP;
        else state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat_i.hit) state_d = ST_FETCH;
        else if (stat_i.cmd == CMD_REMOVE) state_d = ST_SHIFT_RD;
        else state_d = ST_RESP;
      end
      ST_SHIFT_RD: begin
        if (stat_i.idx_end) state_d = ST_RESP;
        else state_d = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: state_d = ST_SHIFT_RD;
      ST_RESP: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        ctrl_o.load_item = in_valid_i;
        ctrl_o.clr_idx   = in_valid_i;
      end
      ST_FETCH: begin
        if (!known_cmd) begin
          ctrl_o.set_res    = 1'b1;
          ctrl_o.res_status = STAT_OK;
        end else if (stat_i.idx_end) begin
          ctrl_o.set_res = 1'b1;
          if (stat_i.cmd != CMD_PUT) begin
            ctrl_o.res_status = STAT_NOT_FOUND;
          end else if (stat_i.full) begin
            ctrl_o.res_status = STAT_FULL;
          end else begin
            ctrl_o.res_status = STAT_OK;
            ctrl_o.mem_we     = 1'b1;
            ctrl_o.inc_count  = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (!stat_i.hit) begin
          ctrl_o.inc_idx = 1'b1;
        end else if (stat_i.cmd == CMD_REMOVE) begin
          ctrl_o.inc_idx = 1'b1;
        end else begin
          ctrl_o.set_res     = 1'b1;
          ctrl_o.res_status  = STAT_OK;
          ctrl_o.mem_we      = (stat_i.cmd == CMD_PUT);
          ctrl_o.res_take_rd = (stat_i.cmd == CMD_GET);
        end
      end
      ST_SHIFT_RD: begin
        if (stat_i.idx_end) begin
          ctrl_o.dec_count  = 1'b1;
          ctrl_o.set_res    = 1'b1;
          ctrl_o.res_status = STAT_OK;
        end
      end
      ST_SHIFT_WR: begin
        ctrl_o.mem_we   = 1'b1;
        ctrl_o.wr_shift = 1'b1;
        ctrl_o.inc_idx  = 1'b1;
      end
      ST_RESP: begin
        ctrl_o.load_out = stat_i.out_free;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ctrl_o.mem_we)
    else $error("entry write while idle");

  a_accept_starts_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_FETCH))
    else $error("accepted beat did not start a search");

  a_resp_follows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RESP && state_d == ST_RESP) |-> ctrl_o.set_res)
    else $error("response state entered without a result");
`endif

endmodule

FILE: src/kvt_datapath.sv
// Entry memory, item and index registers, entry count and result register.
module kvt_datapath
  import kvt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   in_data_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t out_data_o,
  input  ctrl_t   ctrl_i,
  output stat_t   stat_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  entry_t             mem_q [CAPACITY];
  entry_t             rdata_q;
  item_t              item_q;
  logic [CW-1:0]      idx_q;
  logic [CW-1:0]      count_q;
  logic [STAT_W-1:0]  res_status_q;
  logic [VALUE_W-1:0] res_rd_q;
  logic               out_valid_q;
  result_t            out_data_q;

  logic [CW-1:0] wr_idx;
  entry_t        wr_data;

  assign wr_idx  = ctrl_i.wr_shift ? CW'(idx_q - CW'(1)) : idx_q;
  assign wr_data = ctrl_i.wr_shift ? rdata_q : entry_t'{key: item_q.key, value: item_q.value};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_we) mem_q[wr_idx[AW-1:0]] <= wr_data;
    rdata_q <= mem_q[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) item_q <= in_data_i;
    if (ctrl_i.set_res) begin
      res_status_q <= ctrl_i.res_status;
      res_rd_q     <= ctrl_i.res_take_rd ? rdata_q.value : '0;
    end
    if (ctrl_i.load_out) begin
      out_data_q.status      <= res_status_q;
      out_data_q.read_value  <= res_rd_q;
      out_data_q.entry_count <= ENTRY_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr_idx) idx_q <= '0;
      else if (ctrl_i.inc_idx) idx_q <= CW'(idx_q + CW'(1));
      if (ctrl_i.inc_count) count_q <= CW'(count_q + CW'(1));
      else if (ctrl_i.dec_count) count_q <= CW'(count_q - CW'(1));
      if (ctrl_i.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.cmd      = item_q.cmd;
  assign stat_o.idx_end  = (idx_q >= count_q);
  assign stat_o.hit      = (rdata_q.key == item_q.key);
  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == CW'($past(count_q) + CW'(1)) || count_q == CW'($past(count_q) - CW'(1))))
    else $error("entry count moved by more than one");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.mem_we |-> (wr_idx < CW'(CAPACITY)))
    else $error("entry write beyond capacity");
`endif

endmodule

FILE: src/key_value_table_linear_search.sv
// Top level of the key-value table with linear search.
// Stores up to CAPACITY key/value pairs packed in insertion order in an
// entry memory with one write port and one registered read port. One beat
// is taken at a time: a search reads, then compares each stored entry it
// visits, a remove then moves each later entry down one place (read, then
// write), and a result may wait for a stalled output register. The next
// beat is taken while the previous result still waits in the output
// register.
module key_value_table_linear_search
  import kvt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  item_t   in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  ctrl_t ctrl;
  stat_t stat;

  kvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  kvt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

endmodule

FILE: tb/sv/tb_key_value_table_linear_search.sv
`timescale 1ns / 100ps
// Self-checking testbench for the linear-search key-value table: directed and random traffic.
module tb_key_value_table_linear_search;
  import kvt_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned BEAT_CYCLES = 2 * CAPACITY + 4;
  localparam int unsigned DRAIN_CYCLES = 4 * BEAT_CYCLES;
  localparam longint unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_BEATS = 1920;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  item_t   in_data_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  result_t out_data_o;

  logic [KEY_W-1:0]   table_keys   [CAPACITY];
  logic [VALUE_W-1:0] table_values [CAPACITY];
  logic [ENTRY_W-1:0] table_fill;
  result_t            pending_results [$];

  int unsigned     fail_count = 0;
  longint unsigned cycle_count = 0;
  int unsigned     burst_left = 0;
  bit              sender_idles = 1'b1;
  int unsigned     stall_phase_left = 0;
  stall_mode_e     stall_mode = STALL_NONE;

  key_value_table_linear_search #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one request to the table copy and returns the result it should give.
  function automatic result_t apply_request(item_t req);
    result_t res;
    int      hit_slot;
    int      i;
    res = '0;
    res.status = STAT_OK;
    hit_slot = -1;
    for (i = 0; i < int'(table_fill); i++) begin
      if (hit_slot < 0 && table_keys[i] == $unsigned(req.key)) hit_slot = i;
    end
    case (req.cmd)
      CMD_PUT: begin
        if (hit_slot >= 0) begin
          table_values[hit_slot] = req.value;
        end else if (table_fill >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          table_keys[table_fill] = req.key;
          table_values[table_fill] = req.value;
          table_fill++;
        end
      end
      CMD_GET: begin
        if (hit_slot >= 0) begin
          res.read_value = table_values[hit_slot];
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      CMD_REMOVE: begin
        if (hit_slot >= 0) begin
          for (i = hit_slot + 1; i < int'(table_fill); i++) begin
            table_keys[i-1] = table_keys[i];
            table_values[i-1] = table_values[i];
          end
          table_fill--;
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = table_fill;
    return res;
  endfunction

  // Sends one beat; bursts of random length with random gaps in between.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value);
    item_t       req;
    int unsigned gap;
    req.cmd = cmd;
    req.key = key;
    req.value = value;
    if (burst_left == 0) begin
      if ($urandom_range(0, 15) == 0) sender_idles = ~sender_idles;
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_request(req));
  endtask

  task automatic test_empty_table();
    send_request(CMD_GET, 32'h0000_0000, 32'h1234_5678);
    send_request(CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_edge_values();
    send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'h8000_0001, 32'h0000_0000);
    send_request(CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(CMD_REMOVE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'hFFFF_FFFF, 32'h5555_5555);
  endtask

  task automatic test_fill_to_capacity();
    logic [KEY_W-1:0] key;
    key = 32'd1;
    while (table_fill < CAPACITY) begin
      send_request(CMD_PUT, key, $urandom);
      key++;
    end
    send_request(CMD_PUT, 32'h0000_1000, 32'hAAAA_AAAA);
    send_request(CMD_PUT, 32'h8000_0000, 32'h0F0F_0F0F);
    send_request(CMD_REMOVE, 32'h8000_0000, 32'h0000_0000);
    send_request(CMD_REMOVE, key - 32'd1, 32'h0000_0000);
  endtask

  // Phases with a key pool and a bias toward filling, draining or mixed traffic.
  task automatic test_random_traffic();
    logic [KEY_W-1:0] key_pool [32];
    logic [KEY_W-1:0] key;
    logic [CMD_W-1:0] cmd;
    int unsigned      n, i, pick, pool_size, phase_left;
    int unsigned      put_weight, get_weight, remove_weight;
    phase_left = 0;
    pool_size = 1;
    put_weight = 0;
    get_weight = 0;
    remove_weight = 0;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(60, 250);
        pool_size = $urandom_range(2, 32);
        for (i = 0; i < 32; i++) key_pool[i] = $urandom;
        case ($urandom_range(0, 2))
          0: begin
            put_weight = 60;
            get_weight = 25;
            remove_weight = 10;
          end
          1: begin
            put_weight = 15;
            get_weight = 25;
            remove_weight = 55;
          end
          default: begin
            put_weight = 40;
            get_weight = 30;
            remove_weight = 25;
          end
        endcase
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < put_weight) cmd = CMD_PUT;
      else if (pick < put_weight + get_weight) cmd = CMD_GET;
      else if (pick < put_weight + get_weight + remove_weight) cmd = CMD_REMOVE;
      else cmd = CMD_UNUSED;
      pick = $urandom_range(0, 19);
      if (pick == 0) key = $urandom;
      else if (pick == 1) key = key_pool[$urandom_range(0, pool_size - 1)]
                                ^ (32'd1 << $urandom_range(0, 31));
      else key = key_pool[$urandom_range(0, pool_size - 1)];
      send_request(cmd, key, $urandom);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_phase_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_phase_left = $urandom_range(32, 256);
    end
    stall_phase_left--;
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall_i <= stall_phase_left[1];
      default:        out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          fail_count++;
        end
        if (out_data_o.read_value !== want.read_value) begin
          $error("read_value: expected %h, actual %h", want.read_value,
                 out_data_o.read_value);
          fail_count++;
        end
        if (out_data_o.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count,
                 out_data_o.entry_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    table_fill = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_edge_values();
    test_fill_to_capacity();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/kvt_pkg.sv
src/kvt_ctrl.sv
src/kvt_datapath.sv
src/key_value_table_linear_search.sv
tb/sv/tb_key_value_table_linear_search.sv
